FILE: design/mhpq_pkg.sv
// ============================================================================
// mhpq_pkg
// Shared types and codes for the binary max-heap priority queue.
// ============================================================================
package mhpq_pkg;

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_EXTRACT = 3'd1,
        OP_DELETE  = 3'd2,
        OP_PEEK    = 3'd3,
        OP_CLEAR   = 3'd4,
        OP_APPEND  = 3'd5,
        OP_BUILD   = 3'd6,
        OP_NOP     = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    localparam logic [31:0] NEG_ONE = 32'hFFFF_FFFF;

    // request handed from the front end to the heap engine
    typedef struct packed {
        t_opcode     opcode;
        logic [31:0] key_value;
        logic [9:0]  position;
    } t_request;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_UP_RD,
        S_UP_WAIT,
        S_UP_CMP,
        S_RM_RD,
        S_RM_WAIT,
        S_RM_WR,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_WL,
        S_DN_CMP,
        S_DN_SWAP,
        S_PK_WAIT,
        S_PK_DONE,
        S_BLD_NEXT,
        S_DONE
    } t_state;

    function automatic logic key_gt(input logic [31:0] a, input logic [31:0] b);
        key_gt = $signed(a) > $signed(b);
    endfunction

endpackage

FILE: design/mhpq_ram.sv
// ============================================================================
// mhpq_ram
// Generic single-port RAM with registered read.
// ============================================================================
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/mhpq_front.sv
// ============================================================================
// mhpq_front
// Input stage and two-entry request queue feeding the heap engine.
// ============================================================================
module mhpq_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [2:0]          i_opcode,
    input  logic [31:0]         i_key_value,
    input  logic [9:0]          i_position,
    output logic                o_req_valid,
    input  logic                i_req_take,
    output mhpq_pkg::t_request  o_req
);

    mhpq_pkg::t_request r_q [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;
    logic               push;
    logic               pop;

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_req_valid = (r_cnt != 2'd0);
    assign pop         = o_req_valid && i_req_take;
    assign o_req       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{opcode: mhpq_pkg::t_opcode'(i_opcode),
                           key_value: i_key_value, position: i_position};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: design/mhpq_engine.sv
// ============================================================================
// mhpq_engine
// Heap sequencer: sift-up, sift-down, remove and build over one RAM port,
// with an output register toward the result channel.
// ============================================================================
module mhpq_engine #(
    parameter int CAPACITY = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_take,
    input  mhpq_pkg::t_request  i_req,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [31:0]         o_result_value,
    output logic [1:0]          o_status,
    output logic [$clog2(CAPACITY+1)-1:0] o_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    mhpq_pkg::t_state r_state, n_state;
    mhpq_pkg::t_request r_req, n_req;
    logic [CW-1:0] r_size, n_size;
    logic [CW-1:0] r_i, n_i;       // current index
    logic [CW-1:0] r_b, n_b;       // index of largest / parent
    logic [CW-1:0] r_bld, n_bld;   // build loop counter
    logic [31:0]   r_ki, n_ki;     // key at r_i
    logic [31:0]   r_kb, n_kb;     // key at r_b
    logic [31:0]   r_kl, n_kl;     // left child key
    logic          r_rm, n_rm;     // sift-down of a remove, sift-up follows
    logic          r_bldm, n_bldm;
    logic          r_ov, n_ov;
    logic [31:0]   r_val, n_val;
    logic [1:0]    r_st, n_st;

    logic          we;
    logic [AW-1:0] addr;
    logic [31:0]   wdata;
    logic [31:0]   rdata;

    logic [CW:0]   lft, rgt;
    logic [CW-1:0] par;

    mhpq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    assign lft = {r_i, 1'b1};
    assign rgt = {r_i, 1'b0} + (CW+1)'(2);
    assign par = (r_i - CW'(1)) >> 1;

    assign o_valid        = r_ov;
    assign o_result_value = r_val;
    assign o_status       = r_st;
    assign o_entry_count  = r_size;

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_i   <= n_i;
        r_b   <= n_b;
        r_bld <= n_bld;
        r_ki  <= n_ki;
        r_kb  <= n_kb;
        r_kl  <= n_kl;
        r_val <= n_val;
        r_st  <= n_st;
        r_rm  <= n_rm;
        r_bldm <= n_bldm;
        if (!i_rst_n) begin
            r_state <= mhpq_pkg::S_IDLE;
            r_size  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_ov    <= n_ov;
        end
    end

    always_comb begin
        n_state = r_state;
        n_req = r_req; n_size = r_size; n_i = r_i; n_b = r_b; n_bld = r_bld;
        n_ki = r_ki; n_kb = r_kb; n_kl = r_kl; n_rm = r_rm; n_bldm = r_bldm;
        n_val = r_val; n_st = r_st;
        n_ov = r_ov && i_stall;
        o_req_take = 1'b0;
        we = 1'b0;
        addr = r_i[AW-1:0];
        wdata = r_ki;

        case (r_state)
            mhpq_pkg::S_IDLE: begin
                if (i_req_valid && !n_ov) begin
                    o_req_take = 1'b1;
                    n_req = i_req;
                    n_val = '0;
                    n_st  = mhpq_pkg::ST_OK;
                    n_rm  = 1'b0;
                    n_bldm = 1'b0;
                    n_state = mhpq_pkg::S_DISPATCH;
                end
            end
            mhpq_pkg::S_DISPATCH: begin
                n_state = mhpq_pkg::S_DONE;
                case (r_req.opcode)
                    mhpq_pkg::OP_INSERT, mhpq_pkg::OP_APPEND: begin
                        if (r_size >= CAP) begin
                            n_st = mhpq_pkg::ST_FULL;
                        end else begin
                            we = 1'b1;
                            addr = r_size[AW-1:0];
                            wdata = r_req.key_value;
                            n_size = r_size + CW'(1);
                            n_i = r_size;
                            n_ki = r_req.key_value;
                            if (r_req.opcode == mhpq_pkg::OP_INSERT)
                                n_state = mhpq_pkg::S_UP_RD;
                        end
                    end
                    mhpq_pkg::OP_EXTRACT, mhpq_pkg::OP_PEEK: begin
                        if (r_size == '0) begin
                            n_val = mhpq_pkg::NEG_ONE;
                            n_st = mhpq_pkg::ST_EMPTY;
                        end else begin
                            addr = '0;
                            n_i = '0;
                            n_state = (r_req.opcode == mhpq_pkg::OP_PEEK) ?
                                      mhpq_pkg::S_PK_WAIT : mhpq_pkg::S_RM_RD;
                        end
                    end
                    mhpq_pkg::OP_DELETE: begin
                        if (32'(r_req.position) >= 32'(r_size)) begin
                            n_val = mhpq_pkg::NEG_ONE;
                            n_st = mhpq_pkg::ST_RANGE;
                        end else begin
                            addr = AW'(r_req.position);
                            n_i = CW'(r_req.position);
                            n_state = mhpq_pkg::S_RM_RD;
                        end
                    end
                    mhpq_pkg::OP_CLEAR: n_size = '0;
                    mhpq_pkg::OP_BUILD: begin
                        n_bld = r_size >> 1;
                        n_bldm = 1'b1;
                        n_state = mhpq_pkg::S_BLD_NEXT;
                    end
                    default: ;
                endcase
            end
            mhpq_pkg::S_PK_WAIT: begin
                addr = '0;
                n_state = mhpq_pkg::S_PK_DONE;
            end
            mhpq_pkg::S_PK_DONE: begin
                n_val = rdata;
                n_state = mhpq_pkg::S_DONE;
            end
            // remove: removed key arrives, then read last entry
            mhpq_pkg::S_RM_RD: begin
                n_val = rdata;
                addr = AW'(r_size - CW'(1));
                n_state = mhpq_pkg::S_RM_WAIT;
            end
            mhpq_pkg::S_RM_WAIT: begin
                addr = AW'(r_size - CW'(1));
                n_state = mhpq_pkg::S_RM_WR;
            end
            mhpq_pkg::S_RM_WR: begin
                we = 1'b1;
                wdata = rdata;
                n_ki = rdata;
                n_size = r_size - CW'(1);
                n_rm = 1'b1;
                n_state = (r_i < r_size - CW'(1)) ? mhpq_pkg::S_DN_RDL
                                                    : mhpq_pkg::S_DONE;
            end
            // sift-down: r_ki holds key at r_i
            mhpq_pkg::S_DN_RDL: begin
                if (lft >= {1'b0, r_size}) begin
                    n_state = r_bldm ? mhpq_pkg::S_BLD_NEXT :
                              (r_rm ? mhpq_pkg::S_UP_RD : mhpq_pkg::S_DONE);
                end else begin
                    addr = lft[AW-1:0];
                    n_state = mhpq_pkg::S_DN_RDR;
                end
            end
            mhpq_pkg::S_DN_RDR: begin
                n_kl = rdata;
                addr = rgt[AW-1:0];
                n_state = mhpq_pkg::S_DN_WL;
            end
            mhpq_pkg::S_DN_WL: begin
                addr = rgt[AW-1:0];
                n_state = mhpq_pkg::S_DN_CMP;
            end
            mhpq_pkg::S_DN_CMP: begin
                n_b = r_i; n_kb = r_ki;
                if (mhpq_pkg::key_gt(r_kl, r_ki)) begin
                    n_b = lft[CW-1:0]; n_kb = r_kl;
                end
                if (rgt < {1'b0, r_size} && mhpq_pkg::key_gt(rdata, n_kb)) begin
                    n_b = rgt[CW-1:0]; n_kb = rdata;
                end
                if (n_b == r_i) begin
                    n_state = r_bldm ? mhpq_pkg::S_BLD_NEXT :
                              (r_rm ? mhpq_pkg::S_UP_RD : mhpq_pkg::S_DONE);
                end else begin
                    we = 1'b1;
                    wdata = n_kb;
                    n_state = mhpq_pkg::S_DN_SWAP;
                end
            end
            mhpq_pkg::S_DN_SWAP: begin
                we = 1'b1;
                addr = r_b[AW-1:0];
                wdata = r_ki;
                n_i = r_b;
                n_state = mhpq_pkg::S_DN_RDL;
            end
            mhpq_pkg::S_BLD_NEXT: begin
                if (r_bld == '0) begin
                    n_state = mhpq_pkg::S_DONE;
                end else begin
                    addr = AW'(r_bld - CW'(1));
                    n_i = r_bld - CW'(1);
                    n_bld = r_bld - CW'(1);
                    n_state = mhpq_pkg::S_UP_WAIT;
                end
            end
            // sift-up: r_ki holds key at r_i
            mhpq_pkg::S_UP_RD: begin
                if (r_i == '0) begin
                    n_state = mhpq_pkg::S_DONE;
                end else begin
                    addr = par[AW-1:0];
                    n_b = par;
                    n_state = mhpq_pkg::S_UP_WAIT;
                end
            end
            mhpq_pkg::S_UP_WAIT: begin
                if (r_bldm) begin
                    n_ki = rdata;
                    n_state = mhpq_pkg::S_DN_RDL;
                end else begin
                    addr = r_b[AW-1:0];
                    n_state = mhpq_pkg::S_UP_CMP;
                end
            end
            mhpq_pkg::S_UP_CMP: begin
                if (mhpq_pkg::key_gt(r_ki, rdata)) begin
                    // parent moves down into r_i, key keeps climbing
                    we = 1'b1;
                    wdata = rdata;
                    n_i = r_b;
                    n_state = mhpq_pkg::S_UP_RD;
                end else begin
                    n_state = mhpq_pkg::S_DONE;
                end
            end
            mhpq_pkg::S_DONE: begin
                n_ov = 1'b1;
                n_state = mhpq_pkg::S_IDLE;
            end
            default: n_state = mhpq_pkg::S_IDLE;
        endcase

        // sift-up keeps the moving key out of memory until it lands
        if (r_state == mhpq_pkg::S_UP_RD && r_i == '0 && !r_bldm) begin
            we = 1'b1;
            addr = '0;
            wdata = r_ki;
        end
        if (r_state == mhpq_pkg::S_UP_CMP && !mhpq_pkg::key_gt(r_ki, rdata)) begin
            we = 1'b1;
            addr = r_i[AW-1:0];
            wdata = r_ki;
        end
    end

endmodule

FILE: design/max_heap_priority_queue_top.sv
// ============================================================================
// max_heap_priority_queue_top
// Binary max-heap of signed 32-bit keys with one result per request.
// ============================================================================
// Input channel: i_valid/o_stall carry opcode, key and position. A request
// is taken when i_valid is high and o_stall is low. A two-entry queue sits in
// front of the heap engine, so requests keep flowing while a result waits.
// Output channel: o_valid/i_stall carry result value, status and entry count.
// Every request gives exactly one result, in order.
// Clear, append, no-op, peek and error cases finish without a sift;
// insert climbs level by level, extract and delete descend level by level
// and then climb; build runs a sift-down for every non-leaf.
// All heap steps share one single-port RAM, which sets the rate: one request
// is worked on at a time.
// Reset (synchronous, active low) empties the heap and drops queued
// requests; RAM contents are not cleared. While i_stall is high the result
// holds and the engine takes no new request once its output is full.
// ============================================================================
module max_heap_priority_queue_top #(
    parameter int CAPACITY = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [2:0]                     i_opcode,
    input  logic signed [31:0]             i_key_value,
    input  logic [9:0]                     i_position,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [31:0]             o_result_value,
    output logic [1:0]                     o_status,
    output logic [$clog2(CAPACITY+1)-1:0]  o_entry_count
);

    mhpq_pkg::t_request req;
    logic               req_valid;
    logic               req_take;
    logic [31:0]        res_value;

    mhpq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_key_value (i_key_value),
        .i_position  (i_position),
        .o_req_valid (req_valid),
        .i_req_take  (req_take),
        .o_req       (req)
    );

    mhpq_engine #(.CAPACITY(CAPACITY)) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (req_valid),
        .o_req_take     (req_take),
        .i_req          (req),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (res_value),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count)
    );

    assign o_result_value = $signed(res_value);

endmodule

FILE: design/mhpq_checker.sv
// ============================================================================
// mhpq_checker
// Port-level checks for the max-heap priority queue.
// ============================================================================
module mhpq_checker #(
    parameter int CAPACITY = 1024
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [31:0]                   o_result_value,
    input logic [1:0]                    o_status,
    input logic [$clog2(CAPACITY+1)-1:0] o_entry_count
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_value))
        else $error("result changed while stalled");

    a_empty_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == mhpq_pkg::ST_EMPTY |->
        o_result_value == mhpq_pkg::NEG_ONE && o_entry_count == '0)
        else $error("empty status with bad value or count");

    a_range_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == mhpq_pkg::ST_RANGE |->
        o_result_value == mhpq_pkg::NEG_ONE)
        else $error("range status with bad value");

    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == mhpq_pkg::ST_FULL |->
        o_entry_count == ($clog2(CAPACITY+1))'(CAPACITY))
        else $error("full status below capacity");

endmodule

bind max_heap_priority_queue_top mhpq_checker #(.CAPACITY(CAPACITY)) u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_result_value (o_result_value),
    .o_status       (o_status),
    .o_entry_count  (o_entry_count)
);
